FILE: sv/assert_macros.svh
// Assertion macros shared by the timer RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)

`define ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

FILE: sv/bst_pkg.sv
// Types, codes and constants of the bounded step timer.
package bst_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int PRESCALE_WIDTH = 16;
  localparam int CMD_WIDTH      = 2;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  // Item commands
  localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_START = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_STOP  = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_WIDTH-1:0] REG_START    = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_STOP     = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_STEP     = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INTERVAL = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DOWN     = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WRAP     = 3'd5;

  // Register reset values
  localparam logic [VALUE_WIDTH-1:0]    STEP_RESET     = VALUE_WIDTH'(1);
  localparam logic [PRESCALE_WIDTH-1:0] INTERVAL_RESET = PRESCALE_WIDTH'(10);

  typedef logic [VALUE_WIDTH-1:0]    value_t;
  typedef logic [PRESCALE_WIDTH-1:0] prescale_t;
  typedef logic [CMD_WIDTH-1:0]      cmd_t;

  typedef struct packed {
    value_t    start_value;
    value_t    stop_value;
    value_t    step_value;
    prescale_t interval_ticks;
    logic      count_down;
    logic      wrap_around;
  } cfg_t;

  typedef struct packed {
    cmd_t   command;
    value_t write_data;
  } in_item_t;

  typedef struct packed {
    value_t timer_value;
    logic   running;
    logic   value_published;
  } out_item_t;

endpackage

FILE: sv/bst_if.sv
// Valid/ready channel interfaces for timer items and timer results.
interface bst_in_if;
  import bst_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t write_data;

  modport source (output valid, output command, output write_data, input ready);
  modport sink   (input valid, input command, input write_data, output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;

  logic   valid;
  logic   ready;
  value_t timer_value;
  logic   running;
  logic   value_published;

  modport source (output valid, output timer_value, output running,
                  output value_published, input ready);
  modport sink   (input valid, input timer_value, input running,
                  input value_published, output ready);
endinterface

FILE: sv/bst_regs.sv
// APB configuration registers of the bounded step timer.
module bst_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bst_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [bst_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [bst_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output bst_pkg::cfg_t                       cfg
);
  import bst_pkg::*;

  logic [REG_IDX_WIDTH-1:0] reg_idx;
  logic                     wr_en;
  cfg_t                     cfg_r;
  cfg_t                     cfg_nxt;

  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Decode the write transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_START:    cfg_nxt.start_value    = pwdata[VALUE_WIDTH-1:0];
        REG_STOP:     cfg_nxt.stop_value     = pwdata[VALUE_WIDTH-1:0];
        REG_STEP:     cfg_nxt.step_value     = pwdata[VALUE_WIDTH-1:0];
        REG_INTERVAL: cfg_nxt.interval_ticks = pwdata[PRESCALE_WIDTH-1:0];
        REG_DOWN:     cfg_nxt.count_down     = pwdata[0];
        REG_WRAP:     cfg_nxt.wrap_around    = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_value    <= '0;
      cfg_r.stop_value     <= '0;
      cfg_r.step_value     <= STEP_RESET;
      cfg_r.interval_ticks <= INTERVAL_RESET;
      cfg_r.count_down     <= 1'b0;
      cfg_r.wrap_around    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_START:    prdata = APB_DATA_WIDTH'(cfg_r.start_value);
      REG_STOP:     prdata = APB_DATA_WIDTH'(cfg_r.stop_value);
      REG_STEP:     prdata = APB_DATA_WIDTH'(cfg_r.step_value);
      REG_INTERVAL: prdata = APB_DATA_WIDTH'(cfg_r.interval_ticks);
      REG_DOWN:     prdata = APB_DATA_WIDTH'(cfg_r.count_down);
      REG_WRAP:     prdata = APB_DATA_WIDTH'(cfg_r.wrap_around);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: sv/bst_core.sv
// Timer state and the combinational update for one command item.
`include "assert_macros.svh"

module bst_core (
  input  logic                clk,
  input  logic                rst_n,
  input  bst_pkg::cfg_t       cfg,
  input  logic                item_fire,
  input  bst_pkg::in_item_t   item,
  output bst_pkg::out_item_t  result
);
  import bst_pkg::*;

  value_t    bound_r;
  value_t    bound_nxt;
  logic      run_flag_r;
  logic      run_flag_nxt;
  prescale_t pc_r;
  prescale_t pc_nxt;
  logic      published;

  value_t    stepped;
  prescale_t pc_inc;
  logic      expire;
  logic      neg_v;
  logic      neg_c;
  logic      win_dn;
  logic      win_up;
  value_t    exp_val;
  logic      exp_run;
  logic      exp_pub;

  // Step and window compares on the current value
  assign stepped = cfg.count_down ? bound_r - cfg.step_value : bound_r + cfg.step_value;
  assign neg_v   = bound_r[VALUE_WIDTH-1];
  assign neg_c   = stepped[VALUE_WIDTH-1];
  assign win_dn  = (bound_r >= cfg.stop_value) && (bound_r <= cfg.start_value) && !neg_v;
  assign win_up  = (bound_r >= cfg.start_value) && (bound_r <= cfg.stop_value) && !neg_v;

  // Prescaler: a zero interval acts as one
  assign pc_inc = pc_r + PRESCALE_WIDTH'(1);
  assign expire = (pc_inc >= cfg.interval_ticks) || (pc_inc == '0);

  // Outcome of one expiry
  always_comb begin
    exp_val = bound_r;
    exp_run = 1'b1;
    exp_pub = 1'b0;
    if (cfg.count_down) begin
      if (!win_dn) begin
        if (cfg.wrap_around && ((bound_r < cfg.stop_value) || neg_v || (bound_r == '0))) begin
          exp_val = cfg.start_value;
          exp_pub = 1'b1;
        end else begin
          exp_run = 1'b0;
        end
      end else if (!cfg.wrap_around) begin
        if ((stepped < cfg.stop_value) || neg_c) begin
          exp_run = 1'b0;
        end else begin
          exp_val = stepped;
          exp_pub = 1'b1;
          if (stepped == cfg.stop_value) exp_run = 1'b0;
        end
      end else begin
        exp_pub = 1'b1;
        exp_val = ((stepped < cfg.stop_value) || neg_c) ? cfg.start_value : stepped;
      end
    end else begin
      if (!win_up) begin
        if (cfg.wrap_around && (bound_r > cfg.stop_value) && !neg_v) begin
          exp_val = cfg.start_value;
          exp_pub = 1'b1;
        end else begin
          exp_run = 1'b0;
        end
      end else if (!cfg.wrap_around) begin
        if (stepped > cfg.stop_value) begin
          exp_run = 1'b0;
        end else begin
          exp_val = stepped;
          exp_pub = 1'b1;
          if (stepped == cfg.stop_value) exp_run = 1'b0;
        end
      end else begin
        exp_pub = 1'b1;
        exp_val = (stepped > cfg.stop_value) ? cfg.start_value : stepped;
      end
    end
  end

  // Apply the command
  always_comb begin
    bound_nxt    = bound_r;
    run_flag_nxt = run_flag_r;
    pc_nxt       = pc_r;
    published    = 1'b0;
    case (item.command)
      CMD_TICK: begin
        if (run_flag_r) begin
          if (expire) begin
            pc_nxt       = '0;
            bound_nxt    = exp_val;
            run_flag_nxt = exp_run;
            published    = exp_pub;
          end else begin
            pc_nxt = pc_inc;
          end
        end
      end
      CMD_START: begin
        bound_nxt    = cfg.start_value;
        run_flag_nxt = 1'b1;
        pc_nxt       = '0;
        published    = 1'b1;
      end
      CMD_STOP: begin
        run_flag_nxt = 1'b0;
        pc_nxt       = '0;
      end
      CMD_WRITE: begin
        bound_nxt = item.write_data;
        published = 1'b1;
      end
      default: begin
        bound_nxt = bound_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r    <= '0;
      run_flag_r <= 1'b0;
      pc_r       <= '0;
    end else if (item_fire) begin
      bound_r    <= bound_nxt;
      run_flag_r <= run_flag_nxt;
      pc_r       <= pc_nxt;
    end
  end

  assign result.timer_value     = bound_nxt;
  assign result.running         = run_flag_nxt;
  assign result.value_published = published;

  // A stopped timer keeps its prescaler cleared
  `ASSERT_IMPLY(a_stopped_pc_clear, !run_flag_r, pc_r == '0)
  // Only an accepted start sets the run flag
  `ASSERT_IMPLY(a_run_from_start, $rose(run_flag_r), $past(item_fire) && ($past(item.command) == CMD_START))

endmodule

FILE: sv/bst_obuf.sv
// Two-entry result buffer: output register plus a skid entry.
`include "assert_macros.svh"

module bst_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bst_pkg::out_item_t  push_item,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output bst_pkg::out_item_t  out_item
);
  import bst_pkg::*;

  logic      out_v_r;
  out_item_t out_r;
  logic      skid_v_r;
  out_item_t skid_r;
  logic      head_free;

  assign can_push  = !skid_v_r;
  assign head_free = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (head_free) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload: refill the head from the skid entry first
  always_ff @(posedge clk) begin
    if (head_free) begin
      out_r <= skid_v_r ? skid_r : push_item;
    end else if (push) begin
      skid_r <= push_item;
    end
  end

  // Skid entry only fills behind an occupied head
  `ASSERT_IMPLY(a_skid_behind_head, skid_v_r, out_v_r)
  // Skid entry fills only when the head was stalled
  `ASSERT_IMPLY(a_skid_on_stall, $rose(skid_v_r), $past(out_v_r) && !$past(out_ready))

endmodule

FILE: sv/bounded_step_timer_top.sv
// Bounded step timer: programmable up/down stepping timer with prescaler and reload.
// The block takes one command item per clock (base tick, start, stop or value
// write) and returns exactly one result per item: the timer value, the run
// flag and whether the item published a new value. The whole update, one add
// or subtract of the step and the window compares, completes in the cycle the
// item is accepted, and its result is registered into the output buffer.
// A result register backed by one skid entry lets the input keep
// transferring while a result waits; the input stalls only when both entries
// are full. Registers sit on an APB port at byte address 4*index: start,
// stop, step, interval, count_down, wrap_around. Write them only while idle.
module bounded_step_timer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  bst_in_if.sink                              in_if,
  bst_out_if.source                           out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bst_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [bst_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [bst_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);
  import bst_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t result;
  out_item_t out_item;
  logic      can_push;
  logic      item_fire;

  assign item.command    = in_if.command;
  assign item.write_data = in_if.write_data;
  assign in_if.ready     = can_push;
  assign item_fire       = in_if.valid && can_push;

  bst_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_fire (item_fire),
    .item      (item),
    .result    (result)
  );

  bst_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_fire),
    .push_item (result),
    .can_push  (can_push),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_item  (out_item)
  );

  assign out_if.timer_value     = out_item.timer_value;
  assign out_if.running         = out_item.running;
  assign out_if.value_published = out_item.value_published;

endmodule
